/* design/weighted_dictionary_match_scorer_assert.svh */
// assertion macros for the dictionary match scorer
`ifndef WEIGHTED_DICTIONARY_MATCH_SCORER_ASSERT_SVH
`define WEIGHTED_DICTIONARY_MATCH_SCORER_ASSERT_SVH
`ifndef SYNTHESIS
`define WDMS_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("implication check failed");
`define WDMS_ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define WDMS_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define WDMS_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

/* design/wdms_pkg.sv */
// shared types, constants and helpers for the dictionary match scorer
package wdms_pkg;

  localparam int MAX_NODES = 16384;
  localparam int ALPHA     = 39;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int CHILD_D   = MAX_NODES * ALPHA;
  localparam int CHILD_AW  = $clog2(CHILD_D);
  localparam int SYM_W     = 6;
  localparam int RANK_W    = 24;
  localparam int SUM_W     = 48;
  localparam int HIT_W     = 32;
  localparam int PROD_W    = SUM_W + 10;
  localparam int QUO_W     = PROD_W - 1;

  localparam logic [SYM_W-1:0] SYM_DIGIT0 = 6'd26;
  localparam logic [SYM_W-1:0] SYM_DASH   = 6'd36;
  localparam logic [SYM_W-1:0] SYM_SPACE  = 6'd37;
  localparam logic [SYM_W-1:0] SYM_OTHER  = 6'd38;
  localparam logic [SYM_W-1:0] SYM_LAST   = SYM_W'(ALPHA - 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef logic [NODE_W-1:0]        node_t;
  typedef logic [SYM_W-1:0]         sym_t;
  typedef logic signed [RANK_W-1:0] rank_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE,
    S_INS_RD, S_INS_CHK, S_INS_CLR, S_INS_LINK, S_INS_END,
    S_Q_START, S_Q_ADV0, S_ADV_RD, S_ADV_CHK, S_ADV_FL,
    S_Q_LRD, S_Q_LCHK, S_Q_CHAIN, S_Q_CADD, S_Q_END,
    S_Q_M1, S_Q_M2, S_Q_DS, S_Q_DW,
    S_RB_INIT, S_RB_CRD, S_RB_CCHK, S_RB_FRD, S_RB_FCHK, S_RB_NEXT,
    S_RB_QWAIT, S_RB_UFAIL
  } state_t;

  typedef struct packed {
    logic [CHILD_AW-1:0] child_addr;
    logic                child_we;
    node_t               child_wdata;
    node_t               node_addr;
    logic                link_we;
    node_t               fail_wdata;
    node_t               out_wdata;
    logic                leaf_we;
    logic                leaf_wdata;
    rank_t               rank_wdata;
    logic                q_we;
    node_t               q_waddr;
    node_t               q_wdata;
    node_t               q_raddr;
  } mem_req_t;

  typedef struct packed {
    node_t child_rdata;
    logic  leaf;
    rank_t rank;
    node_t fail;
    node_t out;
    node_t q_rdata;
  } mem_rsp_t;

  function automatic sym_t symbol_of(logic [7:0] ch);
    sym_t s;
    if (ch >= 8'h61 && ch <= 8'h7a) s = SYM_W'(ch - 8'h61);
    else if (ch >= 8'h41 && ch <= 8'h5a) s = SYM_W'(ch - 8'h41);
    else if (ch >= 8'h30 && ch <= 8'h39) s = SYM_DIGIT0 + SYM_W'(ch - 8'h30);
    else if (ch == 8'h2d) s = SYM_DASH;
    else if (ch == 8'h20) s = SYM_SPACE;
    else s = SYM_OTHER;
    return s;
  endfunction

  // row-major child slot: node * alphabet + symbol
  function automatic logic [CHILD_AW-1:0] child_index(node_t n, sym_t s);
    return CHILD_AW'(n) * CHILD_AW'(ALPHA) + CHILD_AW'(s);
  endfunction

endpackage

/* design/wdms_store.sv */
// trie, link, leaf and traversal queue memories
module wdms_store (
  input  logic              clk,
  input  wdms_pkg::mem_req_t req,
  output wdms_pkg::mem_rsp_t rsp
);
  import wdms_pkg::*;

  node_t child_mem [CHILD_D];
  node_t fail_mem  [MAX_NODES];
  node_t out_mem   [MAX_NODES];
  logic  leaf_mem  [MAX_NODES];
  rank_t rank_mem  [MAX_NODES];
  node_t queue_mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (req.child_we) child_mem[req.child_addr] <= req.child_wdata;
    if (req.link_we) begin
      fail_mem[req.node_addr] <= req.fail_wdata;
      out_mem[req.node_addr]  <= req.out_wdata;
    end
    if (req.leaf_we) begin
      leaf_mem[req.node_addr] <= req.leaf_wdata;
      rank_mem[req.node_addr] <= req.rank_wdata;
    end
    if (req.q_we) queue_mem[req.q_waddr] <= req.q_wdata;
    rsp.child_rdata <= child_mem[req.child_addr];
    rsp.fail        <= fail_mem[req.node_addr];
    rsp.out         <= out_mem[req.node_addr];
    rsp.leaf        <= leaf_mem[req.node_addr];
    rsp.rank        <= rank_mem[req.node_addr];
    rsp.q_rdata     <= queue_mem[req.q_raddr];
  end

endmodule

/* design/wdms_div.sv */
// restoring divider, one quotient bit per cycle
module wdms_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [wdms_pkg::QUO_W-1:0]   dividend,
  input  logic [wdms_pkg::HIT_W-1:0]   divisor,
  output logic                         done,
  output logic [wdms_pkg::QUO_W-1:0]   quotient
);
  import wdms_pkg::*;

  localparam int CW = $clog2(QUO_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [HIT_W-1:0] rem_r, rem_nxt;
  logic [HIT_W-1:0] div_r, div_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [HIT_W:0]   shifted;
  logic [HIT_W+1:0] diff;
  logic             ge;

  always_comb begin
    shifted  = {rem_r, quo_r[QUO_W-1]};
    diff     = {1'b0, shifted} - {2'b00, div_r};
    ge       = !diff[HIT_W+1];
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      div_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[HIT_W-1:0] : shifted[HIT_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* design/wdms_ctrl.sv */
// sequencer: trie insertion, link rebuild, automaton stepping and scoring
module wdms_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_operation,
  input  logic [7:0]                       in_char_code,
  input  logic                             in_last,
  input  logic signed [wdms_pkg::RANK_W-1:0] in_rank,
  output wdms_pkg::mem_req_t               req,
  input  wdms_pkg::mem_rsp_t               rsp,
  output logic                             div_start,
  output logic [wdms_pkg::QUO_W-1:0]       div_dividend,
  output logic [wdms_pkg::HIT_W-1:0]       div_divisor,
  input  logic                             div_done,
  input  logic [wdms_pkg::QUO_W-1:0]       div_quotient,
  output logic                             out_valid,
  output logic                             out_kind,
  output logic                             out_status,
  output logic signed [wdms_pkg::SUM_W-1:0] out_score,
  output logic [wdms_pkg::HIT_W-1:0]       out_match_count,
  output logic [wdms_pkg::CNT_W-1:0]       out_node_count
);
  import wdms_pkg::*;
  `include "weighted_dictionary_match_scorer_assert.svh"

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [QUO_W-1:0] MAG_POS = QUO_W'(SUM_MAX);
  localparam logic [QUO_W-1:0] MAG_NEG = MAG_POS + 1'b1;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  sym_t   sym_r, sym_nxt;
  rank_t  rank_r, rank_nxt;
  logic [CNT_W-1:0] nu_r, nu_nxt;
  node_t  cursor_r, cursor_nxt;
  logic   ovf_r, ovf_nxt;
  node_t  match_r, match_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [HIT_W-1:0] hits_r, hits_nxt;
  logic   links_ok_r, links_ok_nxt;
  sym_t   col_r, col_nxt;
  node_t  head_r, head_nxt;
  node_t  tail_r, tail_nxt;
  node_t  u_r, u_nxt;
  node_t  ufail_r, ufail_nxt;
  node_t  v_r, v_nxt;
  node_t  f_r, f_nxt;
  node_t  adv_node_r, adv_node_nxt;
  logic   adv_rb_r, adv_rb_nxt;
  node_t  leaf_r, leaf_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic   neg_r, neg_nxt;
  logic   ov_r, ov_nxt;
  logic signed [SUM_W-1:0] os_r, os_nxt;
  logic [HIT_W-1:0] oc_r, oc_nxt;
  logic   osts_r, osts_nxt;
  logic   okind_r, okind_nxt;

  logic signed [PROD_W-1:0] sum_ext;
  sym_t  adv_sym;
  node_t new_node;

  function automatic logic signed [SUM_W-1:0] sat_add(logic signed [SUM_W-1:0] a,
                                                      rank_t r);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + (SUM_W+1)'(r);
    if (s > (SUM_W+1)'(SUM_MAX)) return SUM_MAX;
    if (s < (SUM_W+1)'(SUM_MIN)) return SUM_MIN;
    return s[SUM_W-1:0];
  endfunction

  assign sum_ext  = PROD_W'(sum_r);
  assign adv_sym  = adv_rb_r ? col_r : sym_r;
  assign new_node = nu_r[NODE_W-1:0];
  assign busy     = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    last_nxt = last_r; sym_nxt = sym_r; rank_nxt = rank_r;
    nu_nxt = nu_r; cursor_nxt = cursor_r; ovf_nxt = ovf_r;
    match_nxt = match_r; sum_nxt = sum_r; hits_nxt = hits_r;
    links_ok_nxt = links_ok_r; col_nxt = col_r;
    head_nxt = head_r; tail_nxt = tail_r; u_nxt = u_r; ufail_nxt = ufail_r;
    v_nxt = v_r; f_nxt = f_r; adv_node_nxt = adv_node_r; adv_rb_nxt = adv_rb_r;
    leaf_nxt = leaf_r; prod_nxt = prod_r; neg_nxt = neg_r;
    ov_nxt = 1'b0; okind_nxt = okind_r;
    os_nxt = os_r; oc_nxt = oc_r; osts_nxt = osts_r;
    req = '0;
    div_start = 1'b0;
    div_dividend = prod_r[PROD_W-1] ? QUO_W'(-prod_r) : QUO_W'(prod_r);
    div_divisor = hits_r;

    unique case (state_r)
      S_INIT: begin
        // root row cleared after reset
        req.child_addr = child_index('0, col_r);
        req.child_we   = 1'b1;
        col_nxt = col_r + 1'b1;
        if (col_r == SYM_LAST) begin
          col_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          last_nxt = in_last;
          sym_nxt  = symbol_of(in_char_code);
          rank_nxt = in_rank;
          state_nxt = (in_operation == OP_INSERT) ? S_INS_RD : S_Q_START;
        end
      end
      S_INS_RD: begin
        req.child_addr = child_index(cursor_r, sym_r);
        state_nxt = ovf_r ? S_INS_END : S_INS_CHK;
      end
      S_INS_CHK: begin
        if (rsp.child_rdata != '0) begin
          cursor_nxt = rsp.child_rdata;
          state_nxt = S_INS_END;
        end else if (nu_r < CNT_W'(MAX_NODES)) begin
          col_nxt = '0;
          state_nxt = S_INS_CLR;
        end else begin
          ovf_nxt = 1'b1;
          state_nxt = S_INS_END;
        end
      end
      S_INS_CLR: begin
        // fresh node: empty child row, not a leaf
        req.child_addr = child_index(new_node, col_r);
        req.child_we   = 1'b1;
        req.node_addr  = new_node;
        req.leaf_we    = (col_r == '0);
        req.rank_wdata = rank_r;
        col_nxt = col_r + 1'b1;
        if (col_r == SYM_LAST) state_nxt = S_INS_LINK;
      end
      S_INS_LINK: begin
        req.child_addr  = child_index(cursor_r, sym_r);
        req.child_we    = 1'b1;
        req.child_wdata = new_node;
        cursor_nxt = new_node;
        nu_nxt = nu_r + 1'b1;
        links_ok_nxt = 1'b0;
        state_nxt = S_INS_END;
      end
      S_INS_END: begin
        state_nxt = S_IDLE;
        if (last_r) begin
          if (!ovf_r && cursor_r != '0) begin
            req.node_addr  = cursor_r;
            req.leaf_we    = 1'b1;
            req.leaf_wdata = 1'b1;
            req.rank_wdata = rank_r;
            links_ok_nxt = 1'b0;
          end
          ov_nxt = 1'b1;
          okind_nxt = KIND_INSERT;
          osts_nxt = ovf_r;
          os_nxt = '0;
          oc_nxt = '0;
          cursor_nxt = '0;
          ovf_nxt = 1'b0;
        end
      end
      S_Q_START: begin
        state_nxt = links_ok_r ? S_Q_ADV0 : S_RB_INIT;
      end
      S_Q_ADV0: begin
        adv_node_nxt = (CNT_W'(match_r) >= nu_r) ? '0 : match_r;
        adv_rb_nxt = 1'b0;
        state_nxt = S_ADV_RD;
      end
      S_ADV_RD: begin
        req.child_addr = child_index(adv_node_r, adv_sym);
        state_nxt = S_ADV_CHK;
      end
      S_ADV_CHK: begin
        req.node_addr = adv_node_r;
        if (rsp.child_rdata != '0 || adv_node_r == '0) begin
          f_nxt = rsp.child_rdata;
          state_nxt = adv_rb_r ? S_RB_FRD : S_Q_LRD;
        end else begin
          state_nxt = S_ADV_FL;
        end
      end
      S_ADV_FL: begin
        adv_node_nxt = rsp.fail;
        state_nxt = S_ADV_RD;
      end
      S_Q_LRD: begin
        match_nxt = f_r;
        req.node_addr = f_r;
        state_nxt = S_Q_LCHK;
      end
      S_Q_LCHK: begin
        // direct hit adds its rank without counting
        if (f_r != '0 && rsp.leaf) sum_nxt = sat_add(sum_r, rsp.rank);
        leaf_nxt = rsp.out;
        state_nxt = S_Q_CHAIN;
      end
      S_Q_CHAIN: begin
        req.node_addr = leaf_r;
        state_nxt = (leaf_r == '0) ? S_Q_END : S_Q_CADD;
      end
      S_Q_CADD: begin
        sum_nxt = sat_add(sum_r, rsp.rank);
        if (hits_r != '1) hits_nxt = hits_r + 1'b1;
        leaf_nxt = rsp.out;
        state_nxt = S_Q_CHAIN;
      end
      S_Q_END: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (hits_r == '0) begin
          ov_nxt = 1'b1;
          okind_nxt = KIND_QUERY;
          osts_nxt = 1'b0;
          os_nxt = '0;
          oc_nxt = '0;
          match_nxt = '0;
          sum_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_Q_M1;
        end
      end
      S_Q_M1: begin
        // x1000 as x1024 - x16 - x8
        prod_nxt = (sum_ext <<< 10) - (sum_ext <<< 4);
        state_nxt = S_Q_M2;
      end
      S_Q_M2: begin
        prod_nxt = prod_r - (sum_ext <<< 3);
        state_nxt = S_Q_DS;
      end
      S_Q_DS: begin
        div_start = 1'b1;
        neg_nxt = prod_r[PROD_W-1];
        state_nxt = S_Q_DW;
      end
      S_Q_DW: begin
        if (div_done) begin
          if (neg_r) os_nxt = (div_quotient > MAG_NEG) ? SUM_MIN
                                : -SUM_W'(div_quotient);
          else os_nxt = (div_quotient > MAG_POS) ? SUM_MAX : SUM_W'(div_quotient);
          ov_nxt = 1'b1;
          okind_nxt = KIND_QUERY;
          osts_nxt = 1'b0;
          oc_nxt = hits_r;
          match_nxt = '0;
          sum_nxt = '0;
          hits_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_RB_INIT: begin
        req.node_addr = '0;
        req.link_we = 1'b1;
        u_nxt = '0; ufail_nxt = '0; col_nxt = '0;
        head_nxt = '0; tail_nxt = '0;
        state_nxt = S_RB_CRD;
      end
      S_RB_CRD: begin
        req.child_addr = child_index(u_r, col_r);
        state_nxt = S_RB_CCHK;
      end
      S_RB_CCHK: begin
        v_nxt = rsp.child_rdata;
        if (rsp.child_rdata == '0) begin
          state_nxt = S_RB_NEXT;
        end else if (u_r == '0) begin
          // depth-one nodes fail to the root
          req.node_addr = rsp.child_rdata;
          req.link_we = 1'b1;
          req.q_we = 1'b1;
          req.q_waddr = tail_r;
          req.q_wdata = rsp.child_rdata;
          tail_nxt = tail_r + 1'b1;
          state_nxt = S_RB_NEXT;
        end else begin
          adv_node_nxt = ufail_r;
          adv_rb_nxt = 1'b1;
          state_nxt = S_ADV_RD;
        end
      end
      S_RB_FRD: begin
        req.node_addr = f_r;
        state_nxt = S_RB_FCHK;
      end
      S_RB_FCHK: begin
        req.node_addr = v_r;
        req.link_we = 1'b1;
        req.fail_wdata = f_r;
        req.out_wdata = (f_r != '0 && rsp.leaf) ? f_r : rsp.out;
        req.q_we = 1'b1;
        req.q_waddr = tail_r;
        req.q_wdata = v_r;
        tail_nxt = tail_r + 1'b1;
        state_nxt = S_RB_NEXT;
      end
      S_RB_NEXT: begin
        req.q_raddr = head_r;
        if (col_r == SYM_LAST) begin
          if (head_r == tail_r) begin
            links_ok_nxt = 1'b1;
            state_nxt = S_Q_ADV0;
          end else begin
            state_nxt = S_RB_QWAIT;
          end
        end else begin
          col_nxt = col_r + 1'b1;
          state_nxt = S_RB_CRD;
        end
      end
      S_RB_QWAIT: begin
        u_nxt = rsp.q_rdata;
        req.node_addr = rsp.q_rdata;
        head_nxt = head_r + 1'b1;
        state_nxt = S_RB_UFAIL;
      end
      S_RB_UFAIL: begin
        ufail_nxt = rsp.fail;
        col_nxt = '0;
        state_nxt = S_RB_CRD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      nu_r <= CNT_W'(1);
      cursor_r <= '0;
      ovf_r <= 1'b0;
      match_r <= '0;
      sum_r <= '0;
      hits_r <= '0;
      links_ok_r <= 1'b0;
      col_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nu_r <= nu_nxt;
      cursor_r <= cursor_nxt;
      ovf_r <= ovf_nxt;
      match_r <= match_nxt;
      sum_r <= sum_nxt;
      hits_r <= hits_nxt;
      links_ok_r <= links_ok_nxt;
      col_r <= col_nxt;
      ov_r <= ov_nxt;
    end
    last_r <= last_nxt; sym_r <= sym_nxt; rank_r <= rank_nxt;
    head_r <= head_nxt; tail_r <= tail_nxt; u_r <= u_nxt; ufail_r <= ufail_nxt;
    v_r <= v_nxt; f_r <= f_nxt; adv_node_r <= adv_node_nxt; adv_rb_r <= adv_rb_nxt;
    leaf_r <= leaf_nxt; prod_r <= prod_nxt; neg_r <= neg_nxt;
    okind_r <= okind_nxt;
    os_r <= os_nxt; oc_r <= oc_nxt; osts_r <= osts_nxt;
  end

  assign out_valid       = ov_r;
  assign out_kind        = okind_r;
  assign out_status      = osts_r;
  assign out_score       = os_r;
  assign out_match_count = oc_r;
  assign out_node_count  = nu_r;

  `WDMS_ASSERT_IMP(a_nodes_range, clk, rst_n, 1'b1,
                   nu_r >= CNT_W'(1) && nu_r <= CNT_W'(MAX_NODES))
  `WDMS_ASSERT_IMP(a_cursor_known, clk, rst_n, 1'b1, CNT_W'(cursor_r) < nu_r)
  `WDMS_ASSERT_IMP(a_result_idle, clk, rst_n, ov_r, !busy)
  `WDMS_ASSERT_NXT(a_query_clears, clk, rst_n, ov_r && okind_r == KIND_QUERY,
                   sum_r == '0 || busy)

endmodule

/* design/weighted_dictionary_match_scorer.sv */
// top level of the weighted dictionary match scorer
// Aho-Corasick style scorer over a 39-symbol alphabet. One character per transaction: start is
// taken when busy is low, and a transaction with last set produces one result, shown for
// exactly one cycle on out_valid; the receiver cannot stall. After reset the block clears the
// root row of the child table. An insert character that creates a node also clears its child
// row, one slot a cycle. A query character steps along suffix links and output-link hits, all
// bound by the single-port trie and node memories. The first query after any dictionary change
// rebuilds all links breadth-first, following suffix-link hops for each node below depth one. A
// final query character with hits also runs the x1000 step and the bit-serial divider.
module weighted_dictionary_match_scorer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_operation,
  input  logic [7:0]                         in_char_code,
  input  logic                               in_last,
  input  logic signed [wdms_pkg::RANK_W-1:0] in_rank,
  output logic                               out_valid,
  output logic                               out_kind,
  output logic                               out_status,
  output logic signed [wdms_pkg::SUM_W-1:0]  out_score,
  output logic [wdms_pkg::HIT_W-1:0]         out_match_count,
  output logic [wdms_pkg::CNT_W-1:0]         out_node_count
);
  import wdms_pkg::*;

  mem_req_t         req;
  mem_rsp_t         rsp;
  logic             div_start;
  logic [QUO_W-1:0] div_dividend;
  logic [HIT_W-1:0] div_divisor;
  logic             div_done;
  logic [QUO_W-1:0] div_quotient;

  wdms_store u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  wdms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  wdms_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_char_code    (in_char_code),
    .in_last         (in_last),
    .in_rank         (in_rank),
    .req             (req),
    .rsp             (rsp),
    .div_start       (div_start),
    .div_dividend    (div_dividend),
    .div_divisor     (div_divisor),
    .div_done        (div_done),
    .div_quotient    (div_quotient),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_status      (out_status),
    .out_score       (out_score),
    .out_match_count (out_match_count),
    .out_node_count  (out_node_count)
  );

endmodule

/* tb/sv/tb.sv */
// testbench for the weighted dictionary match scorer: directed table, then random phases
`timescale 1ns / 100ps

module tb;
  import wdms_pkg::*;

  localparam int  LIMIT_CYCLES = 12000000;
  localparam int  RAND_ITEMS   = 1300;
  localparam longint SAT_HI    = 64'sd140737488355327;
  localparam longint SAT_LO    = -64'sd140737488355328;

  typedef struct {
    logic                     kind;
    logic                     status;
    logic signed [SUM_W-1:0]  score;
    logic [HIT_W-1:0]         count;
    logic [CNT_W-1:0]         nodes;
  } score_t;

  typedef struct {
    logic        op;
    logic [7:0]  ch;
    logic        last;
    rank_t       rank;
    bit          typed;
    score_t      want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_operation = OP_INSERT;
  logic [7:0] in_char_code = '0;
  logic in_last = 1'b0;
  rank_t in_rank = '0;
  logic out_valid, out_kind, out_status;
  logic signed [SUM_W-1:0] out_score;
  logic [HIT_W-1:0] out_match_count;
  logic [CNT_W-1:0] out_node_count;

  weighted_dictionary_match_scorer u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_char_code(in_char_code), .in_last(in_last),
    .in_rank(in_rank), .out_valid(out_valid), .out_kind(out_kind),
    .out_status(out_status), .out_score(out_score),
    .out_match_count(out_match_count), .out_node_count(out_node_count)
  );

  always #4 clk = ~clk;

  // trie mirror
  int     trie_child [int];
  bit     node_leaf [MAX_NODES];
  longint node_rank [MAX_NODES];
  int     node_fail [MAX_NODES];
  int     node_out [MAX_NODES];
  bit     links_ok;
  int     nodes_used = 1;
  int     ins_cur;
  int     walk_state;
  longint rank_sum;
  longint hit_total;
  bit     ins_full;

  score_t pending_scores[$];
  int     errs;
  int     cycles;
  bit     quiet;
  row_t   directed[$];

  function automatic int fold_symbol(logic [7:0] c);
    if (c >= "a" && c <= "z") return c - "a";
    if (c >= "A" && c <= "Z") return c - "A";
    if (c >= "0" && c <= "9") return 26 + (c - "0");
    if (c == "-") return 36;
    if (c == " ") return 37;
    return 38;
  endfunction

  function automatic int goto_of(int u, int s);
    while (u != 0 && !trie_child.exists(u * ALPHA + s)) u = node_fail[u];
    return trie_child.exists(u * ALPHA + s) ? trie_child[u * ALPHA + s] : 0;
  endfunction

  function automatic void relink_trie();
    int fifo[$];
    int u, v, f;
    node_fail[0] = 0;
    node_out[0] = 0;
    for (int c = 0; c < ALPHA; c++)
      if (trie_child.exists(c)) begin
        v = trie_child[c];
        node_fail[v] = 0;
        node_out[v] = 0;
        fifo = {fifo, v};
      end
    while (fifo.size() != 0) begin
      u = fifo.pop_front();
      for (int c = 0; c < ALPHA; c++)
        if (trie_child.exists(u * ALPHA + c)) begin
          v = trie_child[u * ALPHA + c];
          f = goto_of(node_fail[u], c);
          node_fail[v] = f;
          node_out[v] = (f != 0 && node_leaf[f]) ? f : node_out[f];
          fifo = {fifo, v};
        end
    end
    links_ok = 1'b1;
  endfunction

  function automatic void add_rank(longint r);
    longint s;
    s = rank_sum + r;
    if (s > SAT_HI) s = SAT_HI;
    if (s < SAT_LO) s = SAT_LO;
    rank_sum = s;
  endfunction

  // advance the mirror by one transaction; returns 1 when a result is due
  function automatic bit trie_step(logic op, logic [7:0] ch, logic last, rank_t rank,
                                   output score_t res);
    int s, key, leaf;
    bit grew;
    longint q;
    s = fold_symbol(ch);
    res = '{default: '0};
    if (op == OP_INSERT) begin
      grew = 1'b0;
      if (!ins_full) begin
        key = ins_cur * ALPHA + s;
        if (trie_child.exists(key)) ins_cur = trie_child[key];
        else if (nodes_used < MAX_NODES) begin
          trie_child[key] = nodes_used;
          node_leaf[nodes_used] = 1'b0;
          ins_cur = nodes_used;
          nodes_used++;
          grew = 1'b1;
        end else ins_full = 1'b1;
      end
      if (!last) begin
        if (grew) links_ok = 1'b0;
        return 1'b0;
      end
      if (!ins_full && ins_cur != 0) begin
        node_leaf[ins_cur] = 1'b1;
        node_rank[ins_cur] = longint'(rank);
        grew = 1'b1;
      end
      if (grew) links_ok = 1'b0;
      res.kind = KIND_INSERT;
      res.status = ins_full;
      res.nodes = CNT_W'(nodes_used);
      ins_cur = 0;
      ins_full = 1'b0;
      return 1'b1;
    end
    if (!links_ok) relink_trie();
    if (walk_state >= nodes_used) walk_state = 0;
    walk_state = goto_of(walk_state, s);
    if (node_leaf[walk_state]) add_rank(node_rank[walk_state]);
    leaf = node_out[walk_state];
    while (leaf != 0) begin
      add_rank(node_rank[leaf]);
      if (hit_total != 64'hFFFF_FFFF) hit_total++;
      leaf = node_out[leaf];
    end
    if (!last) return 1'b0;
    q = 0;
    if (hit_total != 0) begin
      q = (rank_sum * 1000) / hit_total;
      if (q > SAT_HI) q = SAT_HI;
      if (q < SAT_LO) q = SAT_LO;
    end
    res.kind = KIND_QUERY;
    res.score = SUM_W'(q);
    res.count = HIT_W'(hit_total);
    res.nodes = CNT_W'(nodes_used);
    walk_state = 0;
    rank_sum = 0;
    hit_total = 0;
    return 1'b1;
  endfunction

  task automatic send(logic op, logic [7:0] ch, logic last, rank_t rank,
                      bit typed = 1'b0, score_t want = '{default: '0});
    score_t res;
    if (!quiet && $urandom_range(99) < 33) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_char_code <= ch;
    in_last <= last;
    in_rank <= rank;
    do @(posedge clk); while (busy);
    if (trie_step(op, ch, last, rank, res)) pending_scores = {pending_scores, typed ? want : res};
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_scores.size() != 0);
  endtask

  function automatic logic [7:0] pick_char(int wild_pct);
    string set = "abcdAB-";
    if ($urandom_range(99) < wild_pct) return 8'($urandom_range(255));
    return set[$urandom_range(set.len() - 1)];
  endfunction

  function automatic rank_t pick_rank();
    case ($urandom_range(9))
      0: return rank_t'(24'h7F_FFFF);
      1: return rank_t'(24'h80_0000);
      default: return rank_t'($urandom);
    endcase
  endfunction

  function automatic void add_row(logic op, logic [7:0] ch, logic last, int rank,
                                  bit typed = 0, logic kind = 0, int nodes = 0);
    row_t r;
    r.op = op;
    r.ch = ch;
    r.last = last;
    r.rank = rank_t'(rank);
    r.typed = typed;
    r.want = '{kind: kind, status: 1'b0, score: '0, count: '0, nodes: CNT_W'(nodes)};
    directed = {directed, r};
  endfunction

  // result check
  always @(posedge clk) begin
    score_t w;
    if (rst_n && out_valid) begin
      if (pending_scores.size() == 0) begin
        errs++;
        $display("%0t: unexpected result kind=%0d score=%0d", $time, out_kind, out_score);
      end else begin
        w = pending_scores.pop_front();
        if (out_kind !== w.kind) begin
          errs++;
          $display("%0t: kind exp %0d got %0d", $time, w.kind, out_kind);
        end
        if (out_status !== w.status) begin
          errs++;
          $display("%0t: status exp %0d got %0d", $time, w.status, out_status);
        end
        if (out_score !== w.score) begin
          errs++;
          $display("%0t: score exp %0d got %0d", $time, w.score, out_score);
        end
        if (out_match_count !== w.count) begin
          errs++;
          $display("%0t: match_count exp %0d got %0d", $time, w.count, out_match_count);
        end
        if (out_node_count !== w.nodes) begin
          errs++;
          $display("%0t: node_count exp %0d got %0d", $time, w.nodes, out_node_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int issued, len, ntext;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty dictionary, rank extremes, overwrite, output-link chain
    add_row(OP_QUERY, "x", 1, 0, 1, KIND_QUERY, 1);
    add_row(OP_INSERT, "a", 1, 8388607, 1, KIND_INSERT, 2);
    add_row(OP_INSERT, "A", 1, -8388608, 1, KIND_INSERT, 2);
    add_row(OP_INSERT, "b", 1, 100000, 1, KIND_INSERT, 3);
    add_row(OP_INSERT, "a", 0, 0);
    add_row(OP_INSERT, "b", 1, 65536, 1, KIND_INSERT, 4);
    add_row(OP_QUERY, "a", 0, 0);
    add_row(OP_QUERY, "b", 1, 0);
    add_row(OP_INSERT, "-", 0, 0);
    add_row(OP_INSERT, " ", 0, 0);
    add_row(OP_INSERT, "0", 0, 0);
    add_row(OP_INSERT, "9", 1, 0);
    add_row(OP_QUERY, 8'hFF, 0, 0);
    add_row(OP_QUERY, 8'h00, 0, 0);
    add_row(OP_QUERY, "Z", 0, 0);
    add_row(OP_QUERY, "z", 1, 0);
    // query continues across an insert
    add_row(OP_QUERY, "a", 0, 0);
    add_row(OP_INSERT, "z", 1, -1);
    add_row(OP_QUERY, "b", 1, 0);
    add_row(OP_QUERY, "-", 0, 0);
    add_row(OP_QUERY, " ", 0, 0);
    add_row(OP_QUERY, "0", 0, 0);
    add_row(OP_QUERY, "9", 1, 0);
    foreach (directed[i])
      send(directed[i].op, directed[i].ch, directed[i].last, directed[i].rank,
           directed[i].typed, directed[i].want);

    issued = 0;
    while (issued < RAND_ITEMS) begin
      quiet = (issued > 500 && issued < 700);
      drain();
      repeat ($urandom_range(2, 6)) begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          send(OP_INSERT, pick_char(8), k == len - 1, pick_rank());
          issued++;
        end
      end
      ntext = $urandom_range(8, 20);
      repeat (ntext) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          // occasional stray insert breaks into the text
          if ($urandom_range(99) < 4) begin
            send(OP_INSERT, pick_char(20), $urandom_range(1), pick_rank());
            issued++;
          end
          send(OP_QUERY, pick_char(30), k == len - 1, rank_t'($urandom));
          issued++;
        end
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (errs == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
